[src/assert_macros.svh]
// Assertion shorthands for the pressure pump/valve controller.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Whenever ante holds, cons must hold in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[src/ppv_pkg.sv]
// Shared types and codes for the pressure pump/valve hysteresis controller.
// No dependencies; imported by every module of the block.
package ppv_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_PUMP = 2'd1,
    MODE_VENT = 2'd2
  } ppv_mode_t;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PRESSURE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS_BAND = 1'd1;

  localparam logic [15:0] TARGET_RESET = 16'd1000;
  localparam logic [15:0] BAND_RESET   = 16'd50;

  typedef struct packed {
    logic [15:0] pressure_sample;
    logic [31:0] now_ms;
  } ppv_in_t;

  typedef struct packed {
    logic [1:0]  run_mode;
    logic        pump_on;
    logic        valve_on;
    logic        run_ended;
    logic [31:0] run_length_ms;
    logic [31:0] pump_total_ms;
    logic [31:0] valve_total_ms;
  } ppv_out_t;

  typedef struct packed {
    logic [15:0] target_pressure;
    logic [15:0] hysteresis_band;
  } ppv_cfg_t;

endpackage

[src/ppv_cfg.sv]
// Configuration registers: target pressure and hysteresis band.
// Depends on ppv_pkg for the register indexes and the settings struct.
module ppv_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ppv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppv_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output ppv_pkg::ppv_cfg_t                cfg_o
);
  import ppv_pkg::*;

  ppv_cfg_t cfg_r;
  ppv_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_PRESSURE: cfg_nxt.target_pressure = cfg_wdata;
        CFG_HYSTERESIS_BAND: cfg_nxt.hysteresis_band = cfg_wdata;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_pressure <= TARGET_RESET;
      cfg_r.hysteresis_band <= BAND_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

[src/ppv_ctrl.sv]
// Mode state, run start times and on-time totals, plus the hysteresis
// decision for one sample. Depends on ppv_pkg.
module ppv_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  ppv_pkg::ppv_in_t   item,
  input  ppv_pkg::ppv_cfg_t  cfg,
  output ppv_pkg::ppv_out_t  result
);
  import ppv_pkg::*;

  ppv_mode_t   mode_r, mode_nxt;
  logic [31:0] pump_start_r, pump_start_nxt;
  logic [31:0] valve_start_r, valve_start_nxt;
  logic [31:0] pump_sum_r, pump_sum_nxt;
  logic [31:0] valve_sum_r, valve_sum_nxt;

  logic        over;
  logic [15:0] err_abs;
  logic        outside;
  logic        ended;
  logic [31:0] run_len;

  assign over    = item.pressure_sample > cfg.target_pressure;
  assign err_abs = over ? (item.pressure_sample - cfg.target_pressure)
                        : (cfg.target_pressure - item.pressure_sample);
  assign outside = err_abs > cfg.hysteresis_band;

  always_comb begin
    mode_nxt        = mode_r;
    pump_start_nxt  = pump_start_r;
    valve_start_nxt = valve_start_r;
    pump_sum_nxt    = pump_sum_r;
    valve_sum_nxt   = valve_sum_r;
    ended           = 1'b0;
    run_len         = 32'd0;
    case (mode_r)
      MODE_PUMP: begin
        if (!outside) begin
          run_len      = item.now_ms - pump_start_r;
          pump_sum_nxt = pump_sum_r + run_len;
          mode_nxt     = MODE_IDLE;
          ended        = 1'b1;
        end
      end
      MODE_VENT: begin
        if (!outside) begin
          run_len       = item.now_ms - valve_start_r;
          valve_sum_nxt = valve_sum_r + run_len;
          mode_nxt      = MODE_IDLE;
          ended         = 1'b1;
        end
      end
      default: begin
        // idle, and the unused code treated as idle
        mode_nxt = MODE_IDLE;
        if (outside) begin
          if (over) begin
            valve_start_nxt = item.now_ms;
            mode_nxt        = MODE_VENT;
          end else begin
            pump_start_nxt = item.now_ms;
            mode_nxt       = MODE_PUMP;
          end
        end
      end
    endcase
  end

  always_comb begin
    result.run_mode       = mode_nxt;
    result.pump_on        = (mode_nxt == MODE_PUMP);
    result.valve_on       = (mode_nxt == MODE_VENT);
    result.run_ended      = ended;
    result.run_length_ms  = run_len;
    result.pump_total_ms  = pump_sum_nxt;
    result.valve_total_ms = valve_sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_IDLE;
      pump_start_r  <= 32'd0;
      valve_start_r <= 32'd0;
      pump_sum_r    <= 32'd0;
      valve_sum_r   <= 32'd0;
    end else if (step) begin
      mode_r        <= mode_nxt;
      pump_start_r  <= pump_start_nxt;
      valve_start_r <= valve_start_nxt;
      pump_sum_r    <= pump_sum_nxt;
      valve_sum_r   <= valve_sum_nxt;
    end
  end

endmodule

[src/pressure_pump_valve_hysteresis_ctrl_unit.sv]
// Pressure pump/valve hysteresis controller, top level.
// Instantiates ppv_cfg and ppv_ctrl; uses ppv_pkg and assert_macros.svh.
//
// Usage:
//   in_*  : one request per pressure sample (sample in 0.01 psi, ms timestamp).
//   out_* : one result per sample: mode, pump/valve drive, run end flag,
//           run length and the two wrapping on-time totals.
//   cfg_* : write target pressure (index 0) or hysteresis band (index 1);
//           write only while no request is in flight.
// Pipeline: an accepted request passes through the input register and then
//   the result register before it appears on out_* (two register stages).
// Throughput: one request per cycle unless out_stall holds the pipeline; the
//   decision and total update is a combinational compare/add between the two registers.
// Reset (rst_n low, synchronous): mode idle, start times and totals zero,
//   target 1000, band 50, both pipeline stages empty.
// Stall: while out_stall holds, the result register holds its request; one
//   more request may sit in the input register, after which in_stall rises.
//   Nothing is dropped or repeated.
module pressure_pump_valve_hysteresis_ctrl_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ppv_pkg::ppv_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ppv_pkg::ppv_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [ppv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppv_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ppv_pkg::*;
  `include "assert_macros.svh"

  ppv_cfg_t cfg;
  ppv_out_t result;

  logic     s1_valid_r, s1_valid_nxt;
  ppv_in_t  s1_data_r;
  logic     out_valid_r, out_valid_nxt;
  ppv_out_t out_data_r;
  logic     out_adv;
  logic     s1_go;
  logic     accept;

  ppv_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  ppv_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_go),
    .item   (s1_data_r),
    .cfg    (cfg),
    .result (result)
  );

  // result register frees up when empty or being taken
  assign out_adv  = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && out_adv;
  assign in_stall = s1_valid_r && !out_adv;
  assign accept   = in_valid && !in_stall;

  assign s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
  assign out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data_r <= in_data;
    end
    if (s1_go) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_IMPL(a_end_goes_idle, out_valid_r && out_data_r.run_ended, out_data_r.run_mode == MODE_IDLE, "run ended but mode not idle")
  `ASSERT_IMPL(a_len_only_on_end, out_valid_r && !out_data_r.run_ended, out_data_r.run_length_ms == 32'd0, "run length without run end")
  `ASSERT_ALWAYS(a_drive_exclusive, !(out_valid_r && out_data_r.pump_on && out_data_r.valve_on), "pump and valve driven together")
  `ASSERT_IMPL(a_full_blocks_input, s1_valid_r && out_valid_r && out_stall, in_stall, "input not held while both stages full")

endmodule

[tb/testbench.sv]
// Self-checking testbench for pressure_pump_valve_hysteresis_ctrl_unit.
// Uses ppv_pkg for the request/result structs, mode codes and register indexes;
// an in-file controller predictor supplies the expected result of every request.
module testbench;
  import ppv_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 240;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  ppv_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ppv_out_t out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  pressure_pump_valve_hysteresis_ctrl_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ppv_in_t  sample_q[$];
  ppv_out_t predicted_q[$];
  ppv_out_t mon_want;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       error_count = 0;
  int       quiet_cycles = 0;
  logic [31:0] now_cursor = '0;

  // Controller copy: configuration and state as the block holds them.
  logic [15:0] ctl_target = TARGET_RESET;
  logic [15:0] ctl_band = BAND_RESET;
  ppv_mode_t   ctl_mode = MODE_IDLE;
  logic [31:0] pump_start = '0;
  logic [31:0] valve_start = '0;
  logic [31:0] pump_sum = '0;
  logic [31:0] valve_sum = '0;

  function automatic ppv_out_t step_controller(input ppv_in_t req);
    ppv_out_t    res;
    logic        over;
    logic        outside;
    logic [15:0] err_abs;
    logic [31:0] run_len;
    logic        ended;
    over = req.pressure_sample > ctl_target;
    err_abs = over ? req.pressure_sample - ctl_target : ctl_target - req.pressure_sample;
    outside = err_abs > ctl_band;
    ended = 1'b0;
    run_len = '0;
    case (ctl_mode)
      MODE_PUMP: begin
        if (!outside) begin
          run_len = req.now_ms - pump_start;
          pump_sum += run_len;
          ctl_mode = MODE_IDLE;
          ended = 1'b1;
        end
      end
      MODE_VENT: begin
        if (!outside) begin
          run_len = req.now_ms - valve_start;
          valve_sum += run_len;
          ctl_mode = MODE_IDLE;
          ended = 1'b1;
        end
      end
      default: begin
        ctl_mode = MODE_IDLE;
        if (outside && over) begin
          valve_start = req.now_ms;
          ctl_mode = MODE_VENT;
        end else if (outside) begin
          pump_start = req.now_ms;
          ctl_mode = MODE_PUMP;
        end
      end
    endcase
    res.run_mode = ctl_mode;
    res.pump_on = (ctl_mode == MODE_PUMP);
    res.valve_on = (ctl_mode == MODE_VENT);
    res.run_ended = ended;
    res.run_length_ms = run_len;
    res.pump_total_ms = pump_sum;
    res.valve_total_ms = valve_sum;
    return res;
  endfunction

  // Driver: track register writes, predict on acceptance, offer the next request.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TARGET_PRESSURE: ctl_target = cfg_wdata;
          CFG_HYSTERESIS_BAND: ctl_band = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predicted_q.push_back(step_controller(in_data));
        void'(sample_q.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold the stalled request
      end else if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= sample_q[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Monitor: compare every accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_q.size() == 0) begin
        $error("result with no request outstanding: %h", out_data);
        error_count++;
      end else begin
        mon_want = predicted_q.pop_front();
        if (out_data.run_mode !== mon_want.run_mode) begin
          $error("run_mode: expected %0d, got %0d", mon_want.run_mode, out_data.run_mode);
          error_count++;
        end
        if (out_data.pump_on !== mon_want.pump_on) begin
          $error("pump_on: expected %0d, got %0d", mon_want.pump_on, out_data.pump_on);
          error_count++;
        end
        if (out_data.valve_on !== mon_want.valve_on) begin
          $error("valve_on: expected %0d, got %0d", mon_want.valve_on, out_data.valve_on);
          error_count++;
        end
        if (out_data.run_ended !== mon_want.run_ended) begin
          $error("run_ended: expected %0d, got %0d", mon_want.run_ended, out_data.run_ended);
          error_count++;
        end
        if (out_data.run_length_ms !== mon_want.run_length_ms) begin
          $error("run_length_ms: expected %h, got %h",
                 mon_want.run_length_ms, out_data.run_length_ms);
          error_count++;
        end
        if (out_data.pump_total_ms !== mon_want.pump_total_ms) begin
          $error("pump_total_ms: expected %h, got %h",
                 mon_want.pump_total_ms, out_data.pump_total_ms);
          error_count++;
        end
        if (out_data.valve_total_ms !== mon_want.valve_total_ms) begin
          $error("valve_total_ms: expected %h, got %h",
                 mon_want.valve_total_ms, out_data.valve_total_ms);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[pressure_pump_valve_hysteresis_ctrl_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(input logic [15:0] sample, input logic [31:0] stamp);
    ppv_in_t req;
    req.pressure_sample = sample;
    req.now_ms = stamp;
    sample_q.push_back(req);
  endtask

  // Wait until every request is accepted and every result is back, then settle.
  task automatic drain();
    while (sample_q.size() != 0 || in_valid || predicted_q.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct,
                           input logic [15:0] tgt, input logic [15:0] band,
                           input int count);
    int sel;
    int off;
    int value;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    write_reg(CFG_TARGET_PRESSURE, tgt);
    write_reg(CFG_HYSTERESIS_BAND, band);
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 4)
        off = $urandom_range(0, band);
      else
        off = int'(band) + 1 + $urandom_range(0, 2000);
      value = $urandom_range(0, 1) ? int'(tgt) + off : int'(tgt) - off;
      if (value < 0) value = 0;
      if (value > 65535) value = 65535;
      if (sel >= 8) value = $urandom_range(0, 65535);
      // mostly advance time a little; now and then jump anywhere
      if ($urandom_range(0, 19) == 0)
        now_cursor = $urandom;
      else
        now_cursor += $urandom_range(0, 1000);
      send(value[15:0], now_cursor);
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset configuration: target 1000, band 50.
    send(16'd1000, 32'd0);             // zero error stays idle
    send(16'd1050, 32'd10);            // error equal to band stays idle
    send(16'd950, 32'd20);
    send(16'd1051, 32'd100);           // overpressure opens vent
    send(16'd2000, 32'd150);
    send(16'd1050, 32'd300);           // back in band closes vent
    send(16'd949, 32'hFFFF_FF00);      // underpressure starts pump
    send(16'd0, 32'hFFFF_FFF0);
    send(16'd950, 32'h0000_0100);      // timestamp wrap across the run
    send(16'd0, 32'd5000);
    send(16'd1000, 32'd10);            // timestamp moved backward
    send(16'hFFFF, 32'hFFFF_FFFF);
    send(16'd1000, 32'd0);
    send(16'd900, 32'd0);
    send(16'd1000, 32'hFFFF_FFFF);     // pump total wraps
    send(16'hFFFF, 32'h8000_0000);
    send(16'd1000, 32'h7FFF_FFFF);     // valve total wraps
    drain();

    write_reg(CFG_TARGET_PRESSURE, 16'd0);
    write_reg(CFG_HYSTERESIS_BAND, 16'd0);
    send(16'd0, 32'd1);
    send(16'd1, 32'd2);
    send(16'd0, 32'd3);
    drain();
    write_reg(CFG_TARGET_PRESSURE, 16'hFFFF);
    send(16'hFFFE, 32'd4);
    send(16'hFFFF, 32'd5);
    drain();
    write_reg(CFG_TARGET_PRESSURE, 16'd0);
    write_reg(CFG_HYSTERESIS_BAND, 16'hFFFF);
    send(16'hFFFF, 32'd6);             // widest band never acts
    send(16'hAAAA, 32'h5555_5555);
    drain();

    // Start a pump run, then move the target under it.
    write_reg(CFG_TARGET_PRESSURE, 16'd1000);
    write_reg(CFG_HYSTERESIS_BAND, 16'd50);
    send(16'd800, 32'd7);
    drain();
    write_reg(CFG_TARGET_PRESSURE, 16'd800);
    send(16'd800, 32'd8);
    drain();

    run_phase(0, 0, 16'd1000, 16'd50, PHASE_ITEMS);
    run_phase(63, 0, 16'd0, 16'd0, PHASE_ITEMS);
    run_phase(0, 63, 16'hFFFF, 16'd0, PHASE_ITEMS);
    run_phase(35, 35, 16'h8000, 16'hFFFF, PHASE_ITEMS);
    run_phase(0, 0, 16'd0, 16'hFFFF, PHASE_ITEMS);
    run_phase(63, 0, 16'hFFFF, 16'hFFFF, PHASE_ITEMS);
    run_phase(0, 63, 16'($urandom), 16'($urandom_range(0, 300)), PHASE_ITEMS);
    run_phase(35, 35, 16'($urandom), 16'($urandom_range(0, 5000)), PHASE_ITEMS);

    if (error_count == 0)
      $display("[pressure_pump_valve_hysteresis_ctrl_unit] OK");
    else
      $display("[pressure_pump_valve_hysteresis_ctrl_unit] ERROR");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/ppv_pkg.sv
src/ppv_cfg.sv
src/ppv_ctrl.sv
src/pressure_pump_valve_hysteresis_ctrl_unit.sv
tb/testbench.sv
